FILE: rtl/tspd_pkg.sv
package tspd_pkg;

    // packed input pixel: three bgr byte triples, first image lowest
    localparam int PIX_W = 72;

    // cordic vector widths: x/y hold up to about 1.2e12, z holds turns * 2^32 with headroom
    localparam int XY_W = 42;
    localparam int Z_W  = 34;

    localparam int CORDIC_STEPS = 28;

    // sqrt(3) with 30 fraction bits
    localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;

    // a quarter turn with 32 fraction bits
    localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'sd1073741824);

    // atan(2^-i) / (2*pi), turns with 32 fraction bits
    localparam logic [29:0] TURN_TABLE [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } tspd_vec_t;

    // per-pixel values that ride alongside the angle
    typedef struct packed {
        logic       bg;
        logic       zero;
        logic [7:0] gray;
        logic [7:0] range;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } tspd_side_t;

    function automatic logic [7:0] luma(input logic [7:0] b, input logic [7:0] g,
                                        input logic [7:0] r);
        logic [15:0] acc;
        acc = 16'd29 * {8'd0, b} + 16'd150 * {8'd0, g} + 16'd77 * {8'd0, r} + 16'd128;
        return acc[15:8];
    endfunction

endpackage

FILE: rtl/tspd_front.sv
module tspd_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [tspd_pkg::PIX_W-1:0] in_pixel,
    input  logic [9:0]              threshold,
    output logic                    out_valid,
    output tspd_pkg::tspd_vec_t     out_vec,
    output tspd_pkg::tspd_side_t    out_side
);
    import tspd_pkg::*;

    // luma stage
    logic             a_valid_reg;
    logic [7:0]       l1_reg, l2_reg, l3_reg;
    logic [PIX_W-1:0] pix_reg;

    // statistics stage
    logic              b_valid_reg;
    tspd_side_t        b_side_reg, b_side_next;
    logic signed [8:0] diff_a_reg, diff_a_next;
    logic signed [10:0] diff_b_reg, diff_b_next;

    // scaling stage
    logic                   c_valid_reg;
    tspd_side_t             c_side_reg;
    logic signed [XY_W-1:0] x_c_reg, y_c_reg, x_c_next, y_c_next;

    // quadrant fold stage
    logic       d_valid_reg;
    tspd_side_t d_side_reg;
    tspd_vec_t  d_vec_reg, d_vec_next;

    logic [7:0]  mx, mn;
    logic [9:0]  sum;
    logic [19:0] lhs, rhs;
    logic [23:0] pick;

    always_comb
    begin
        mx = l1_reg;
        mn = l1_reg;
        if (l2_reg > mx) mx = l2_reg;
        if (l3_reg > mx) mx = l3_reg;
        if (l2_reg < mn) mn = l2_reg;
        if (l3_reg < mn) mn = l3_reg;
        sum = {2'b00, l1_reg} + {2'b00, l2_reg} + {2'b00, l3_reg};
        lhs = {2'b00, mx - mn, 10'd0};
        rhs = {10'd0, threshold} * {10'd0, sum};
        // brightest image, earlier image wins a tie
        priority if (mx == l1_reg)
            pick = pix_reg[23:0];
        else if (mx == l2_reg)
            pick = pix_reg[47:24];
        else
            pick = pix_reg[71:48];
        diff_a_next = $signed({1'b0, l1_reg}) - $signed({1'b0, l3_reg});
        diff_b_next = $signed({2'b00, l2_reg, 1'b0}) - $signed({3'b000, l1_reg})
                    - $signed({3'b000, l3_reg});
        b_side_next.bg    = lhs < rhs;
        b_side_next.zero  = (diff_a_next == 9'sd0) && (diff_b_next == 11'sd0);
        b_side_next.gray  = l1_reg;
        b_side_next.range = mx - mn;
        b_side_next.blue  = pick[7:0];
        b_side_next.green = pick[15:8];
        b_side_next.red   = pick[23:16];
    end

    always_comb
    begin
        x_c_next = XY_W'(diff_b_reg) <<< 30;
        y_c_next = XY_W'(diff_a_reg * SQRT3_Q30);
    end

    // rotate left half plane into the right one
    always_comb
    begin
        d_vec_next.x = x_c_reg;
        d_vec_next.y = y_c_reg;
        d_vec_next.z = '0;
        if (x_c_reg < 0)
        begin
            if (y_c_reg >= 0)
            begin
                d_vec_next.x = y_c_reg;
                d_vec_next.y = -x_c_reg;
                d_vec_next.z = QUARTER_TURN;
            end
            else
            begin
                d_vec_next.x = -y_c_reg;
                d_vec_next.y = x_c_reg;
                d_vec_next.z = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_reg     <= luma(in_pixel[7:0],   in_pixel[15:8],  in_pixel[23:16]);
            l2_reg     <= luma(in_pixel[31:24], in_pixel[39:32], in_pixel[47:40]);
            l3_reg     <= luma(in_pixel[55:48], in_pixel[63:56], in_pixel[71:64]);
            pix_reg    <= in_pixel;
            b_side_reg <= b_side_next;
            diff_a_reg <= diff_a_next;
            diff_b_reg <= diff_b_next;
            c_side_reg <= b_side_reg;
            x_c_reg    <= x_c_next;
            y_c_reg    <= y_c_next;
            d_side_reg <= c_side_reg;
            d_vec_reg  <= d_vec_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_vec   = d_vec_reg;
    assign out_side  = d_side_reg;

endmodule

FILE: rtl/tspd_cordic_cell.sv
module tspd_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  tspd_pkg::tspd_vec_t  in_vec,
    input  tspd_pkg::tspd_side_t in_side,
    output logic                 out_valid,
    output tspd_pkg::tspd_vec_t  out_vec,
    output tspd_pkg::tspd_side_t out_side
);
    import tspd_pkg::*;

    localparam logic signed [Z_W-1:0] TURN = Z_W'(TURN_TABLE[STEP]);

    logic       valid_reg;
    tspd_vec_t  vec_reg, vec_next;
    tspd_side_t side_reg;
    logic signed [XY_W-1:0] dx, dy;

    // one vectoring micro-rotation, shifts floor toward minus infinity
    always_comb
    begin
        dx = in_vec.y >>> STEP;
        dy = in_vec.x >>> STEP;
        if (in_vec.y >= 0)
        begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + TURN;
        end
        else
        begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

FILE: rtl/three_step_phase_decode_unit.sv
// pipeline: an accepted input item passes through 4 front stages, 28 cordic
//   cells and 1 output register before its result item appears
// throughput: one item per cycle; the whole chain stalls only while a
//   finished result waits at the output and m_tready is low
// reset: rst_n asynchronous active low, clears all valid flags and sets
//   noise_threshold to 102; no clearing pass, items accepted right away
module three_step_phase_decode_unit #(
    parameter int PHASE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,

    // configuration: noise_threshold
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [9:0] cfg_data,

    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_blue, first_green, first_red, second_blue, second_green,
    // second_red, third_blue, third_green, third_red (8 bits each)
    input  logic [71:0] s_tdata,

    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    // wrapped_phase (PHASE_BITS), gray_level, fringe_range, out_blue,
    // out_green, out_red (8 bits each), zero padded to whole bytes
    output logic [((PHASE_BITS + 40 + 7) / 8) * 8 - 1:0] m_tdata,
    // background
    output logic        m_tuser
);
    import tspd_pkg::*;

    localparam int OUT_W = ((PHASE_BITS + 40 + 7) / 8) * 8;
    localparam int SHIFT = 32 - PHASE_BITS;
    localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(64'sd1 <<< (SHIFT - 1));
    localparam logic signed [Z_W-1:0] PH_MAX = Z_W'((64'sd1 <<< (PHASE_BITS - 1)) - 64'sd1);
    localparam logic signed [Z_W-1:0] PH_MIN = Z_W'(-(64'sd1 <<< (PHASE_BITS - 1)));

    // global pipeline advance: move whenever the output slot is free or being taken
    logic en;

    logic [9:0] threshold_reg;

    // chain links: index 0 is the front end, index k+1 the output of cell k
    logic       link_valid [CORDIC_STEPS + 1];
    tspd_vec_t  link_vec   [CORDIC_STEPS + 1];
    tspd_side_t link_side  [CORDIC_STEPS + 1];

    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg;

    tspd_vec_t             last_vec;
    tspd_side_t            last_side;
    logic signed [Z_W-1:0] z_round, z_quant, z_sat;
    logic [PHASE_BITS-1:0] phase;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= 10'd102;
        else if (cfg_valid)
            threshold_reg <= cfg_data;
    end

    // luma, statistics, scaling and quadrant fold
    tspd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_pixel  (s_tdata),
        .threshold (threshold_reg),
        .out_valid (link_valid[0]),
        .out_vec   (link_vec[0]),
        .out_side  (link_side[0])
    );

    // row of cordic cells, one micro-rotation each
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cell
        tspd_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (link_valid[k]),
            .in_vec    (link_vec[k]),
            .in_side   (link_side[k]),
            .out_valid (link_valid[k + 1]),
            .out_vec   (link_vec[k + 1]),
            .out_side  (link_side[k + 1])
        );
    end

    assign last_vec  = link_vec[CORDIC_STEPS];
    assign last_side = link_side[CORDIC_STEPS];

    // round half up to PHASE_BITS fraction bits, then saturate
    always_comb
    begin
        z_round = last_vec.z + ROUND_HALF;
        z_quant = z_round >>> SHIFT;
        if (z_quant > PH_MAX)
            z_sat = PH_MAX;
        else if (z_quant < PH_MIN)
            z_sat = PH_MIN;
        else
            z_sat = z_quant;
        // background and the all-equal case give zero phase
        if (last_side.bg || last_side.zero)
            phase = '0;
        else
            phase = z_sat[PHASE_BITS-1:0];
        m_tdata_next = OUT_W'({last_side.red, last_side.green, last_side.blue,
                               last_side.range, last_side.gray, phase});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (en)
            m_tvalid_reg <= link_valid[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= last_side.bg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
